// File: rtl/core/tdd_pkg.sv
// ----------------------------------------------------------------------------
// tdd_pkg
// Shared constants, types and helpers for the TSC density deposit block.
// ----------------------------------------------------------------------------
package tdd_pkg;

  localparam int GRID_CELLS  = 64;
  localparam int FRAC_BITS   = 12;
  localparam int ACC_WIDTH   = 32;
  localparam int WEIGHT_BITS = 16;

  localparam int POS_W  = 18;
  localparam int CELL_W = 6;
  localparam int OUT_W  = 32;
  localparam int IDX_W  = $clog2(GRID_CELLS);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int CELLS  = GRID_CELLS * GRID_CELLS;

  // raw axis weight carries 2*FRAC_BITS+2 fraction bits; 3*S^2 still fits
  localparam int RAW_W    = 2 * FRAC_BITS + 2;
  localparam int SQ_OP_W  = FRAC_BITS + 1;
  localparam int MUL_W    = (SQ_OP_W > WEIGHT_BITS) ? SQ_OP_W : WEIGHT_BITS;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int Q_W      = PROD_W - WEIGHT_BITS + 1;
  localparam int WGT_SH   = RAW_W - WEIGHT_BITS;

  localparam int WGT_STEPS = 6;
  localparam int DEP_STEPS = 9;
  localparam int STEP_W    = 4;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_DEPOSIT = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } tdd_op_e;

  typedef struct packed {
    logic              load;
    logic              issue_wgt;
    logic              issue_dep;
    logic [STEP_W-1:0] step;
    logic              clr_wr;
    logic [ADDR_W-1:0] clr_addr;
    logic              rd_cell;
    logic              out_load;
  } tdd_cmd_t;

  // round half up from RAW_W fraction bits down to WEIGHT_BITS
  function automatic logic [WEIGHT_BITS-1:0] tdd_to_weight(input logic [RAW_W-1:0] raw);
    logic [RAW_W:0] t;
    t = '0;
    if (WGT_SH > 0) begin
      t = {1'b0, raw} + ((RAW_W+1)'(1) << (WGT_SH - 1));
      return WEIGHT_BITS'(t >> WGT_SH);
    end else begin
      return WEIGHT_BITS'(raw) << (-WGT_SH);
    end
  endfunction

endpackage

// File: rtl/core/tdd_ctrl.sv
// ----------------------------------------------------------------------------
// tdd_ctrl
// Sequencer: clear sweep, weight steps, deposit steps, cell read, result out.
// ----------------------------------------------------------------------------
module tdd_ctrl import tdd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  tdd_op_e  op_i,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output tdd_cmd_t cmd_o
);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CLR  = 3'd2;
  localparam logic [2:0] ST_WGT  = 3'd3;
  localparam logic [2:0] ST_DEP  = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] WGT_LAST  = ADDR_W'(WGT_STEPS);
  localparam logic [ADDR_W-1:0] DEP_LAST  = ADDR_W'(DEP_STEPS + 1);

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  tdd_cmd_t          cmd;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd          = '0;
    cmd.step     = cnt_q[STEP_W-1:0];
    cmd.clr_addr = cnt_q;
    s_ready_o    = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLR: begin
        cmd.clr_wr = 1'b1;
        cnt_d      = cnt_q + ADDR_W'(1);
        if (cnt_q == LAST_ADDR) begin
          cnt_d   = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_FIN;
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        cnt_d     = '0;
        if (s_valid_i) begin
          cmd.load = 1'b1;
          unique case (op_i)
            OP_CLEAR:   state_d = ST_CLR;
            OP_DEPOSIT: state_d = ST_WGT;
            OP_READ:    state_d = ST_RD;
            default:    state_d = ST_FIN;
          endcase
        end
      end
      ST_WGT: begin
        cmd.issue_wgt = (cnt_q < ADDR_W'(WGT_STEPS));
        cnt_d         = cnt_q + ADDR_W'(1);
        if (cnt_q == WGT_LAST) begin
          cnt_d   = '0;
          state_d = ST_DEP;
        end
      end
      ST_DEP: begin
        cmd.issue_dep = (cnt_q < ADDR_W'(DEP_STEPS));
        cnt_d         = cnt_q + ADDR_W'(1);
        if (cnt_q == DEP_LAST) begin
          cnt_d   = '0;
          state_d = ST_FIN;
        end
      end
      ST_RD: begin
        cmd.rd_cell = 1'b1;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        if (!out_vld_q || m_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  assign out_vld_d = cmd.out_load | (out_vld_q & ~m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_valid_o = out_vld_q;
  assign cmd_o     = cmd;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_vld_q || m_ready_i))
    else $error("result register overwritten while still pending");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> !s_ready_o)
    else $error("second item taken while one is in work");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.issue_wgt, cmd.issue_dep, cmd.clr_wr, cmd.rd_cell, cmd.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule

// File: rtl/core/tdd_datapath.sv
// ----------------------------------------------------------------------------
// tdd_datapath
// Item registers, shared multiplier, axis weights, grid memories, result reg.
// ----------------------------------------------------------------------------
module tdd_datapath import tdd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdd_cmd_t          cmd_i,
  input  tdd_op_e           operation_i,
  input  logic              species_i,
  input  logic [POS_W-1:0]  pos_x_i,
  input  logic [POS_W-1:0]  pos_y_i,
  input  logic [CELL_W-1:0] cell_x_i,
  input  logic [CELL_W-1:0] cell_y_i,
  output logic [OUT_W-1:0]  density_first_o,
  output logic [OUT_W-1:0]  density_second_o,
  output logic              saturated_o,
  output logic              done_res_o
);

  localparam logic [SQ_OP_W-1:0] S_ONE    = SQ_OP_W'(1) << FRAC_BITS;
  localparam logic [RAW_W-1:0]   THREE_S2 = RAW_W'(3) << (2 * FRAC_BITS);

  // item registers
  tdd_op_e           op_q;
  logic              species_q;
  logic [POS_W-1:0]  pos_x_q, pos_y_q;
  logic [CELL_W-1:0] cell_x_q, cell_y_q;

  // weights
  logic [WEIGHT_BITS-1:0] wx_q [3];
  logic [WEIGHT_BITS-1:0] wy_q [3];

  // pipeline
  logic [PROD_W-1:0] mul_q;
  logic [1:0]        s1_sel_q;
  logic              s1_ax_q, s1_wgt_q, s1_dep_q, s2_dep_q;
  logic [ADDR_W-1:0] addr1_q, addr2_q;
  logic [Q_W-1:0]    q_q;
  logic              clip_q;

  // memories
  logic [ACC_WIDTH-1:0] grid_first_mem  [CELLS];
  logic [ACC_WIDTH-1:0] grid_second_mem [CELLS];
  logic [ACC_WIDTH-1:0] rd_first_q, rd_second_q;

  // result register
  logic [OUT_W-1:0] dens_first_q, dens_second_q;
  logic             sat_q, done_q;

  // ---- stage 1: operand select and multiply ----
  logic                   axis_y;
  logic [1:0]             wsel, di, dj;
  logic [FRAC_BITS-1:0]   u;
  logic [SQ_OP_W-1:0]     twice_u, dev, sq_op;
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [IDX_W-1:0]       cx, cy;

  always_comb begin
    axis_y  = (cmd_i.step >= STEP_W'(3));
    wsel    = axis_y ? 2'(cmd_i.step - STEP_W'(3)) : cmd_i.step[1:0];
    u       = axis_y ? pos_y_q[FRAC_BITS-1:0] : pos_x_q[FRAC_BITS-1:0];
    twice_u = {u, 1'b0};
    dev     = (twice_u >= S_ONE) ? (twice_u - S_ONE) : (S_ONE - twice_u);
    unique case (wsel)
      2'd0:    sq_op = S_ONE - SQ_OP_W'(u);
      2'd1:    sq_op = dev;
      default: sq_op = SQ_OP_W'(u);
    endcase
    di = (cmd_i.step >= STEP_W'(6)) ? 2'd2 : ((cmd_i.step >= STEP_W'(3)) ? 2'd1 : 2'd0);
    dj = 2'(cmd_i.step - STEP_W'({di, 1'b0}) - STEP_W'(di));
    cx = pos_x_q[FRAC_BITS +: IDX_W] + IDX_W'(di) - IDX_W'(1);
    cy = pos_y_q[FRAC_BITS +: IDX_W] + IDX_W'(dj) - IDX_W'(1);
    if (cmd_i.issue_dep) begin
      mul_a = MUL_W'(wx_q[di]);
      mul_b = MUL_W'(wy_q[dj]);
    end else begin
      mul_a = MUL_W'(sq_op);
      mul_b = MUL_W'(sq_op);
    end
  end

  // ---- stage 2: weight rounding / product rounding ----
  logic [RAW_W-1:0]  raw;
  logic [PROD_W:0]   rnd;

  always_comb begin
    unique case (s1_sel_q)
      2'd1:    raw = THREE_S2 - RAW_W'(mul_q);
      default: raw = RAW_W'(mul_q) << 1;
    endcase
    rnd = {1'b0, mul_q} + ((PROD_W+1)'(1) << (WEIGHT_BITS - 1));
  end

  // ---- stage 3: saturating accumulate ----
  logic [ACC_WIDTH-1:0] acc_old, acc_new;
  logic [ACC_WIDTH:0]   sum;
  logic                 sat;
  logic                 we_first, we_second;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic [ACC_WIDTH-1:0] wr_data;
  logic                 rd_en;

  always_comb begin
    acc_old   = species_q ? rd_second_q : rd_first_q;
    sum       = {1'b0, acc_old} + (ACC_WIDTH+1)'(q_q);
    sat       = sum[ACC_WIDTH];
    acc_new   = sat ? '1 : sum[ACC_WIDTH-1:0];
    we_first  = cmd_i.clr_wr | (s2_dep_q & ~species_q);
    we_second = cmd_i.clr_wr | (s2_dep_q & species_q);
    wr_addr   = cmd_i.clr_wr ? cmd_i.clr_addr : addr2_q;
    wr_data   = cmd_i.clr_wr ? '0 : acc_new;
    rd_addr   = cmd_i.rd_cell ? {cell_y_q[IDX_W-1:0], cell_x_q[IDX_W-1:0]} : addr1_q;
    rd_en     = cmd_i.rd_cell | s1_dep_q;
  end

  always_ff @(posedge clk_i) begin
    if (we_first) begin
      grid_first_mem[wr_addr] <= wr_data;
    end
    if (we_second) begin
      grid_second_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_first_q  <= grid_first_mem[rd_addr];
      rd_second_q <= grid_second_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= operation_i;
      species_q <= species_i;
      pos_x_q   <= pos_x_i;
      pos_y_q   <= pos_y_i;
      cell_x_q  <= cell_x_i;
      cell_y_q  <= cell_y_i;
    end
    mul_q    <= mul_a * mul_b;
    s1_sel_q <= wsel;
    s1_ax_q  <= axis_y;
    addr1_q  <= {cy, cx};
    addr2_q  <= addr1_q;
    q_q      <= Q_W'(rnd >> WEIGHT_BITS);
    if (s1_wgt_q) begin
      if (s1_ax_q) begin
        wy_q[s1_sel_q] <= tdd_to_weight(raw);
      end else begin
        wx_q[s1_sel_q] <= tdd_to_weight(raw);
      end
    end
    if (cmd_i.out_load) begin
      dens_first_q  <= (op_q == OP_READ) ? OUT_W'(rd_first_q) : '0;
      dens_second_q <= (op_q == OP_READ) ? OUT_W'(rd_second_q) : '0;
      sat_q         <= clip_q;
      done_q        <= (op_q != OP_NONE);
    end
  end

  // pipeline valids and saturation flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_wgt_q <= 1'b0;
      s1_dep_q <= 1'b0;
      s2_dep_q <= 1'b0;
      clip_q   <= 1'b0;
    end else begin
      s1_wgt_q <= cmd_i.issue_wgt;
      s1_dep_q <= cmd_i.issue_dep;
      s2_dep_q <= s1_dep_q;
      if (cmd_i.clr_wr) begin
        clip_q <= 1'b0;
      end else if (s2_dep_q && sat) begin
        clip_q <= 1'b1;
      end
    end
  end

  assign density_first_o  = dens_first_q;
  assign density_second_o = dens_second_q;
  assign saturated_o      = sat_q;
  assign done_res_o       = done_q;

endmodule

// File: rtl/core/tsc_density_deposit_top.sv
// ----------------------------------------------------------------------------
// tsc_density_deposit_top
// Two-species TSC mass deposit onto a periodic 64x64 grid, with clear and read.
// ----------------------------------------------------------------------------
// Deposit: 6 weight squares and 9 products through one shared multiplier,
//   then a 3-stage read-modify-write.
// Clear sweeps both grids at one cell per cycle.
// Throughput: one item in work at a time; next item is taken the cycle after
//   the result enters the output register, even if that result is not yet taken.
// Reset: async active low; then a clearing pass over all 4096 cells zeroes
//   both grids with tready low.
// ----------------------------------------------------------------------------
module tsc_density_deposit_top import tdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // pos_x[17:0], pos_y[35:18], cell_x[41:36],
                                     // cell_y[47:42]
  input  logic [2:0]  s_axis_tuser,  // operation[1:0], species[2]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // density_first[31:0], density_second[63:32]
  output logic [1:0]  m_axis_tuser   // saturated[0], done_res[1]
);

  tdd_cmd_t          cmd;
  tdd_op_e           operation;
  logic [OUT_W-1:0]  dens_first, dens_second;
  logic              saturated, done_res;

  assign operation = tdd_op_e'(s_axis_tuser[1:0]);

  // controller: sequences clear sweeps, the weight and deposit steps
  tdd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .op_i      (operation),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  // datapath: multiplier, weights, both grid memories, result register
  tdd_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operation_i      (operation),
    .species_i        (s_axis_tuser[2]),
    .pos_x_i          (s_axis_tdata[17:0]),
    .pos_y_i          (s_axis_tdata[35:18]),
    .cell_x_i         (s_axis_tdata[41:36]),
    .cell_y_i         (s_axis_tdata[47:42]),
    .density_first_o  (dens_first),
    .density_second_o (dens_second),
    .saturated_o      (saturated),
    .done_res_o       (done_res)
  );

  assign m_axis_tdata = {dens_second, dens_first};
  assign m_axis_tuser = {done_res, saturated};

endmodule

// File: verif/tdd_checker.sv
// ----------------------------------------------------------------------------
// tdd_checker
// Watches both stream channels of the TSC density deposit block, keeps its
// own copy of the two species grids and the clip flag, predicts each result
// item and compares it field by field against what the block returns.
// ----------------------------------------------------------------------------
module tdd_checker import tdd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [47:0]       s_axis_tdata,   // pos_x, pos_y, cell_x, cell_y
  input  logic [2:0]        s_axis_tuser,   // operation, species
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [63:0]       m_axis_tdata,   // density_first, density_second
  input  logic [1:0]        m_axis_tuser,   // saturated, done_res
  output int unsigned       errors_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [OUT_W-1:0] dens_first;
    logic [OUT_W-1:0] dens_second;
    logic             saturated;
    logic             done;
  } cell_result_t;

  localparam longint unsigned ACC_MAX = (64'd1 << ACC_WIDTH) - 64'd1;

  logic [ACC_WIDTH-1:0] first_grid  [CELLS];
  logic [ACC_WIDTH-1:0] second_grid [CELLS];
  logic                 clip_seen;

  cell_result_t         pending_results [$];
  cell_result_t         got;
  cell_result_t         want;
  int unsigned          mismatches = 0;

  function automatic void clear_grids();
    for (int i = 0; i < CELLS; i++) begin
      first_grid[i]  = '0;
      second_grid[i] = '0;
    end
    clip_seen = 1'b0;
  endfunction

  // round half up by sh bits, or widen when sh is negative
  function automatic longint unsigned fix_round(input longint unsigned raw, input int sh);
    if (sh > 0) begin
      return (raw + (64'd1 << (sh - 1))) >> sh;
    end
    return raw << (-sh);
  endfunction

  // left / centre / right weights of one axis at WEIGHT_BITS fraction bits
  function automatic logic [2:0][WEIGHT_BITS-1:0] tsc_weights(input logic [POS_W-1:0] pos);
    logic [2:0][WEIGHT_BITS-1:0] w;
    longint unsigned             s;
    longint unsigned             u;
    longint unsigned             dev;
    s   = 64'd1 << FRAC_BITS;
    u   = longint'(pos) & (s - 64'd1);
    dev = (2 * u >= s) ? 2 * u - s : s - 2 * u;
    w[0] = WEIGHT_BITS'(fix_round(2 * (s - u) * (s - u), WGT_SH));
    w[1] = WEIGHT_BITS'(fix_round(3 * s * s - dev * dev, WGT_SH));
    w[2] = WEIGHT_BITS'(fix_round(2 * u * u, WGT_SH));
    return w;
  endfunction

  function automatic void spread_particle(input logic sp, input logic [POS_W-1:0] px,
                                          input logic [POS_W-1:0] py);
    logic [2:0][WEIGHT_BITS-1:0] wx;
    logic [2:0][WEIGHT_BITS-1:0] wy;
    int                          kx;
    int                          ky;
    int                          idx;
    longint unsigned             q;
    longint unsigned             acc;
    wx = tsc_weights(px);
    wy = tsc_weights(py);
    kx = int'((px >> FRAC_BITS) % GRID_CELLS);
    ky = int'((py >> FRAC_BITS) % GRID_CELLS);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        idx = ((ky + GRID_CELLS - 1 + j) % GRID_CELLS) * GRID_CELLS
            + (kx + GRID_CELLS - 1 + i) % GRID_CELLS;
        q   = fix_round(longint'(wx[i]) * longint'(wy[j]), WEIGHT_BITS);
        acc = sp ? longint'(second_grid[idx]) : longint'(first_grid[idx]);
        if (acc + q > ACC_MAX) begin
          acc       = ACC_MAX;
          clip_seen = 1'b1;
        end else begin
          acc = acc + q;
        end
        if (sp) second_grid[idx] = ACC_WIDTH'(acc);
        else    first_grid[idx]  = ACC_WIDTH'(acc);
      end
    end
  endfunction

  function automatic cell_result_t apply_operation(input tdd_op_e op, input logic sp,
                                                   input logic [POS_W-1:0]  px,
                                                   input logic [POS_W-1:0]  py,
                                                   input logic [CELL_W-1:0] cx,
                                                   input logic [CELL_W-1:0] cy);
    cell_result_t res;
    int           idx;
    res      = '0;
    res.done = 1'b1;
    case (op)
      OP_CLEAR:   clear_grids();
      OP_DEPOSIT: spread_particle(sp, px, py);
      OP_READ: begin
        idx = (int'(cy) % GRID_CELLS) * GRID_CELLS + int'(cx) % GRID_CELLS;
        res.dens_first  = OUT_W'(first_grid[idx]);
        res.dens_second = OUT_W'(second_grid[idx]);
      end
      default: res.done = 1'b0;
    endcase
    res.saturated = clip_seen;
    return res;
  endfunction

  task automatic check_field(input string what, input logic [OUT_W-1:0] want_v,
                             input logic [OUT_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
    end
  endtask

  // result side is handled before the input side so that an item accepted
  // in the same cycle cannot cover a result that arrived unasked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_grids();
      pending_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.dens_first  = m_axis_tdata[OUT_W-1:0];
        got.dens_second = m_axis_tdata[2*OUT_W-1:OUT_W];
        got.saturated   = m_axis_tuser[0];
        got.done        = m_axis_tuser[1];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result item with nothing outstanding, data %0h user %0h",
                     $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = pending_results.pop_front();
          check_field("density_first",  want.dens_first,  got.dens_first);
          check_field("density_second", want.dens_second, got.dens_second);
          check_field("saturated",      OUT_W'(want.saturated), OUT_W'(got.saturated));
          check_field("done_res",       OUT_W'(want.done),      OUT_W'(got.done));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(apply_operation(
          tdd_op_e'(s_axis_tuser[1:0]), s_axis_tuser[2],
          s_axis_tdata[POS_W-1:0], s_axis_tdata[2*POS_W-1:POS_W],
          s_axis_tdata[2*POS_W +: CELL_W], s_axis_tdata[2*POS_W+CELL_W +: CELL_W]));
    end
    errors_o  <= mismatches;
    pending_o <= pending_results.size();
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the TSC density deposit block. A directed set
// hits position extremes, grid wraparound, every operation and reads of the
// touched cells; then random items run through four flow-control phases.
// Prediction and comparison live in tdd_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import tdd_pkg::*;

  localparam int          PHASE_ITEMS = 432;
  // hang guard: the run stops with an error at this cycle count
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;   // pos_x[17:0], pos_y[35:18], cell_x[41:36],
                                     // cell_y[47:42]
  logic [2:0]  s_axis_tuser  = '0;   // operation[1:0], species[2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // density_first[31:0], density_second[63:32]
  logic [1:0]  m_axis_tuser;         // saturated[0], done_res[1]

  int unsigned fail_cnt;
  int unsigned outstanding;
  int unsigned cycle_cnt = 0;
  int          idle_pct  = 0;        // chance the sender skips a cycle
  int          stall_pct = 0;        // chance the receiver holds tready low
  int          op_count [4];

  // cells that recent deposits landed on; random reads and deposits aim here
  // so that reads see piled-up sums instead of mostly empty cells
  logic [CELL_W-1:0] hot_x [8];
  logic [CELL_W-1:0] hot_y [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tsc_density_deposit_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tdd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (fail_cnt),
    .pending_o     (outstanding)
  );

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drives one item and returns at the edge that accepts it. tvalid only
  // drops when a gap is drawn, so back-to-back items keep it high.
  task automatic send_item(input tdd_op_e op, input logic sp,
                           input logic [POS_W-1:0]  px, input logic [POS_W-1:0]  py,
                           input logic [CELL_W-1:0] cx, input logic [CELL_W-1:0] cy);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cy, cx, py, px};
    s_axis_tuser  <= {sp, op};
    op_count[op]++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sender goes quiet until every result in flight has been taken
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  initial begin
    tdd_op_e           op;
    logic              sp;
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
    int                r;
    int                slot;

    for (int i = 0; i < 4; i++) op_count[i] = 0;
    for (int i = 0; i < 8; i++) begin
      hot_x[i] = CELL_W'($urandom_range(GRID_CELLS - 1));
      hot_y[i] = CELL_W'($urandom_range(GRID_CELLS - 1));
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // the block runs its grid clearing pass now; send_item just waits on tready

    // ---- directed ----------------------------------------------------------
    send_item(OP_CLEAR,   1'b0, '0, '0, '0, '0);
    send_item(OP_READ,    1'b0, '0, '0, 6'd0, 6'd0);
    // position zero: fraction 0, left neighbours wrap to cell 63
    send_item(OP_DEPOSIT, 1'b0, 18'h00000, 18'h00000, '0, '0);
    // all ones: cell 63, fraction just under one, right neighbours wrap to 0
    send_item(OP_DEPOSIT, 1'b1, 18'h3FFFF, 18'h3FFFF, '0, '0);
    // particle exactly on a cell centre, then just either side of it
    send_item(OP_DEPOSIT, 1'b0, {6'd5, 12'h800}, {6'd5, 12'h800}, '0, '0);
    send_item(OP_DEPOSIT, 1'b1, {6'd5, 12'h7FF}, {6'd5, 12'h801}, '0, '0);
    send_item(OP_DEPOSIT, 1'b0, {6'd63, 12'h001}, {6'd0, 12'hFFE}, '0, '0);
    // unused code with every other field at its maximum
    send_item(OP_NONE,    1'b1, 18'h3FFFF, 18'h3FFFF, 6'd63, 6'd63);
    send_item(OP_READ,    1'b0, '0, '0, 6'd63, 6'd63);
    send_item(OP_READ,    1'b1, '0, '0, 6'd0,  6'd0);
    send_item(OP_READ,    1'b0, '0, '0, 6'd1,  6'd1);
    send_item(OP_READ,    1'b0, '0, '0, 6'd63, 6'd0);
    send_item(OP_READ,    1'b0, '0, '0, 6'd62, 6'd62);
    send_item(OP_READ,    1'b0, '0, '0, 6'd5,  6'd5);
    send_item(OP_READ,    1'b0, '0, '0, 6'd4,  6'd6);
    send_item(OP_READ,    1'b0, '0, '0, 6'd6,  6'd4);
    send_item(OP_READ,    1'b0, '0, '0, 6'd0,  6'd63);
    // alternating bit patterns, then read the cell they landed on
    send_item(OP_DEPOSIT, 1'b1, 18'h2AAAA, 18'h15555, 6'h2A, 6'h15);
    send_item(OP_READ,    1'b0, 18'h15555, 18'h2AAAA, 6'd42, 6'd21);
    // clear with sums present and check they are gone
    send_item(OP_CLEAR,   1'b1, 18'h3FFFF, 18'h3FFFF, 6'd63, 6'd63);
    send_item(OP_READ,    1'b0, '0, '0, 6'd5,  6'd5);
    send_item(OP_READ,    1'b0, '0, '0, 6'd63, 6'd63);

    // ---- random, four flow-control phases ------------------------------------
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 80; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // clears are rare since each one costs a full grid sweep
        r = $urandom_range(999);
        if (r < 6)        op = OP_CLEAR;
        else if (r < 560) op = OP_DEPOSIT;
        else if (r < 970) op = OP_READ;
        else              op = OP_NONE;
        sp   = 1'($urandom_range(1));
        slot = $urandom_range(7);
        px   = POS_W'($urandom_range(262143));
        py   = POS_W'($urandom_range(262143));
        cx   = CELL_W'($urandom_range(GRID_CELLS - 1));
        cy   = CELL_W'($urandom_range(GRID_CELLS - 1));
        if ($urandom_range(99) < 65) begin
          px[POS_W-1:FRAC_BITS] = hot_x[slot];
          py[POS_W-1:FRAC_BITS] = hot_y[slot];
        end
        // fractions at the weight breakpoints now and then
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(4))
            0:       px[FRAC_BITS-1:0] = 12'h000;
            1:       px[FRAC_BITS-1:0] = 12'h7FF;
            2:       px[FRAC_BITS-1:0] = 12'h800;
            3:       px[FRAC_BITS-1:0] = 12'h801;
            default: px[FRAC_BITS-1:0] = 12'hFFF;
          endcase
        end
        // reads mostly land inside a hot cell's 3x3 footprint, wrap included
        if ($urandom_range(99) < 70) begin
          cx = hot_x[slot] + CELL_W'($urandom_range(2)) - 6'd1;
          cy = hot_y[slot] + CELL_W'($urandom_range(2)) - 6'd1;
        end
        if (op == OP_DEPOSIT && $urandom_range(3) == 0) begin
          hot_x[slot] = px[POS_W-1:FRAC_BITS];
          hot_y[slot] = py[POS_W-1:FRAC_BITS];
        end
        send_item(op, sp, px, py, cx, cy);
      end
    end

    // ---- wind down -----------------------------------------------------------
    drain();
    repeat (40) @(negedge clk_i);

    $display("Sent %0d items: %0d deposits, %0d reads, %0d clears, %0d unused codes",
             op_count[OP_DEPOSIT] + op_count[OP_READ] + op_count[OP_CLEAR] + op_count[OP_NONE],
             op_count[OP_DEPOSIT], op_count[OP_READ], op_count[OP_CLEAR], op_count[OP_NONE]);
    $display("Phases: free flow, sender gaps, receiver stalls, mixed; %0d mismatches, %0d left",
             fail_cnt, outstanding);
    if (fail_cnt == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
